>>> rtl/fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_pkg
// shared constants, types and the twiddle table for the radix-2 fft engine
// ----------------------------------------------------------------------------
package fft_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int LOG_MAX     = 12;
    localparam int ADDR_W      = 12;
    localparam int CNT_W       = 13;
    localparam int TW_DEPTH    = MAX_POINTS / 2;
    localparam int TW_ADDR_W   = 11;
    localparam int TW_BITS     = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 32;
    localparam int LG_W        = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OUT,
        S_BF_RD,
        S_BF_MUL,
        S_BF_ADD,
        S_BF_WA,
        S_BF_WB
    } t_state;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_SUM,
        WR_DIF
    } t_wr_sel;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr_a;
        logic [ADDR_W-1:0]    rd_addr_b;
        logic [TW_ADDR_W-1:0] tw_addr;
        logic                 mul_en;
        logic                 add_en;
        logic                 wr_en;
        t_wr_sel              wr_sel;
        logic [ADDR_W-1:0]    wr_addr;
        logic                 load_conj;
        logic                 out_load;
        logic [ADDR_W-1:0]    out_idx;
        logic                 out_last;
        logic                 out_inv;
        logic [LG_W-1:0]      out_lg;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    typedef logic [2*TW_BITS-1:0] t_tw_rom [TW_DEPTH];

    // size clamp, zero taken as one, anything above the maximum as the maximum
    function automatic logic [LG_W-1:0] f_eff_log2(input logic [LG_W-1:0] lg);
        logic [LG_W-1:0] l;
        l = lg;
        if (l < LG_W'(1)) begin
            l = LG_W'(1);
        end
        if (l > LG_W'(LOG_MAX)) begin
            l = LG_W'(LOG_MAX);
        end
        return l;
    endfunction

    function automatic logic [ADDR_W-1:0] f_bitrev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++) begin
            r[ADDR_W-1-b] = v[b];
        end
        return r;
    endfunction

    // restoring shift-subtract division, used only while building the table
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // integer taylor series in q30, result rounded to q15
    function automatic logic [TW_BITS-1:0] f_trig(input longint unsigned x, input bit odd);
        longint unsigned term;
        longint unsigned d;
        longint          sum;
        longint          q;
        term = odd ? x : (64'd1 << 30);
        sum  = longint'(term);
        for (int n = 1; n <= 12; n++) begin
            d = odd ? longint'(2 * n) * longint'(2 * n + 1)
                    : longint'(2 * n - 1) * longint'(2 * n);
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = f_udiv(term, d);
            if (n[0] == 1'b1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + (longint'(1) << (30 - TW_BITS))) >>> (31 - TW_BITS);
        if (q > ((longint'(1) << (TW_BITS - 1)) - 1)) begin
            q = (longint'(1) << (TW_BITS - 1)) - 1;
        end
        return q[TW_BITS-1:0];
    endfunction

    // packed {cos, sin} per entry
    function automatic t_tw_rom f_build_tw();
        t_tw_rom          rom;
        longint unsigned  a;
        longint unsigned  x;
        logic [TW_BITS-1:0] c;
        logic [TW_BITS-1:0] s;
        bit               upper;
        for (int t = 0; t < TW_DEPTH; t++) begin
            upper = (4 * t) > MAX_POINTS;
            a = upper ? longint'(TW_DEPTH - t) : longint'(t);
            x = (2 * PI_Q30 * a) >> LOG_MAX;
            c = f_trig(x, 1'b0);
            s = f_trig(x, 1'b1);
            rom[t] = {(upper ? (~c + TW_BITS'(1)) : c), s};
        end
        return rom;
    endfunction

    localparam t_tw_rom TW_ROM = f_build_tw();

endpackage

>>> rtl/fft_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_in_if
// input channel: operation code and complex sample
// ----------------------------------------------------------------------------
interface fft_in_if;
    import fft_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;

    modport source (output valid, output op, output sample_re, output sample_im,
                    input ready);
    modport sink   (input valid, input op, input sample_re, input sample_im,
                    output ready);
endinterface

>>> rtl/fft_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_out_if
// output channel: transformed bin with its index
// ----------------------------------------------------------------------------
interface fft_out_if;
    import fft_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] bin_re;
    logic signed [DATA_W-1:0] bin_im;
    logic [ADDR_W-1:0]        bin_index;
    logic                     last_bin;

    modport source (output valid, output bin_re, output bin_im, output bin_index,
                    output last_bin, input ready);
    modport sink   (input valid, input bin_re, input bin_im, input bin_index,
                    input last_bin, output ready);
endinterface

>>> rtl/fft_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_datapath
// frame memory, twiddle rom, butterfly arithmetic and output register
// ----------------------------------------------------------------------------
module fft_datapath
    import fft_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [DATA_W-1:0]      o_bin_re,
    output logic signed [DATA_W-1:0]      o_bin_im,
    output logic [ADDR_W-1:0]             o_bin_index,
    output logic                          o_last_bin
);

    logic [2*DATA_W-1:0]  r_mem [MAX_POINTS];
    logic [2*DATA_W-1:0]  r_qa;
    logic [2*DATA_W-1:0]  r_qb;
    logic [2*TW_BITS-1:0] r_tw;

    logic signed [DATA_W+TW_BITS-1:0] r_p_rc, r_p_is, r_p_ic, r_p_rs;
    logic [DATA_W-1:0] r_sum_re, r_sum_im, r_dif_re, r_dif_im;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_bin_re, r_bin_im;
    logic [ADDR_W-1:0]        r_bin_index;
    logic                     r_last_bin;

    logic signed [DATA_W+TW_BITS+1:0] w_acc_re, w_acc_im;
    logic [DATA_W-1:0]     w_tr, w_ti;
    logic [DATA_W-1:0]     w_ld_re, w_ld_im;
    logic [2*DATA_W-1:0]   w_wr_data;
    logic signed [DATA_W+1:0] w_vr, w_vi, w_rr, w_ri;

    // load conversion, conjugate in inverse mode
    always_comb begin
        w_ld_re = DATA_W'(i_sample_re);
        w_ld_im = i_cmd.load_conj ? (DATA_W'(0) - DATA_W'(i_sample_im))
                                  : DATA_W'(i_sample_im);
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_LOAD: w_wr_data = {w_ld_re, w_ld_im};
            WR_SUM:  w_wr_data = {r_sum_re, r_sum_im};
            WR_DIF:  w_wr_data = {r_dif_re, r_dif_im};
            default: w_wr_data = {r_sum_re, r_sum_im};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_qa <= r_mem[i_cmd.rd_addr_a];
            r_qb <= r_mem[i_cmd.rd_addr_b];
            r_tw <= TW_ROM[i_cmd.tw_addr];
        end
    end

    // b times conj-free twiddle (cos - j sin)
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p_rc <= $signed(r_qb[2*DATA_W-1:DATA_W]) * $signed(r_tw[2*TW_BITS-1:TW_BITS]);
            r_p_is <= $signed(r_qb[DATA_W-1:0]) * $signed(r_tw[TW_BITS-1:0]);
            r_p_ic <= $signed(r_qb[DATA_W-1:0]) * $signed(r_tw[2*TW_BITS-1:TW_BITS]);
            r_p_rs <= $signed(r_qb[2*DATA_W-1:DATA_W]) * $signed(r_tw[TW_BITS-1:0]);
        end
    end

    always_comb begin
        w_acc_re = (DATA_W+TW_BITS+2)'(r_p_rc) + (DATA_W+TW_BITS+2)'(r_p_is)
                 + (DATA_W+TW_BITS+2)'(1 << (TW_BITS - 2));
        w_acc_im = (DATA_W+TW_BITS+2)'(r_p_ic) - (DATA_W+TW_BITS+2)'(r_p_rs)
                 + (DATA_W+TW_BITS+2)'(1 << (TW_BITS - 2));
        w_tr = w_acc_re[DATA_W+TW_BITS-2:TW_BITS-1];
        w_ti = w_acc_im[DATA_W+TW_BITS-2:TW_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en) begin
            r_sum_re <= r_qa[2*DATA_W-1:DATA_W] + w_tr;
            r_sum_im <= r_qa[DATA_W-1:0] + w_ti;
            r_dif_re <= r_qa[2*DATA_W-1:DATA_W] - w_tr;
            r_dif_im <= r_qa[DATA_W-1:0] - w_ti;
        end
    end

    // readout: conjugate and scale by 1/n rounding half up in inverse mode
    always_comb begin
        w_vr = (DATA_W+2)'($signed(r_qa[2*DATA_W-1:DATA_W]));
        w_vi = (DATA_W+2)'($signed(r_qa[DATA_W-1:0]));
        w_rr = (w_vr + ((DATA_W+2)'(1) << (i_cmd.out_lg - LG_W'(1)))) >>> i_cmd.out_lg;
        w_ri = ((DATA_W+2)'(0) - w_vi + ((DATA_W+2)'(1) << (i_cmd.out_lg - LG_W'(1))))
               >>> i_cmd.out_lg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_bin_re    <= i_cmd.out_inv ? w_rr[DATA_W-1:0] : w_vr[DATA_W-1:0];
            r_bin_im    <= i_cmd.out_inv ? w_ri[DATA_W-1:0] : w_vi[DATA_W-1:0];
            r_bin_index <= i_cmd.out_idx;
            r_last_bin  <= i_cmd.out_last;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_bin_re        = r_bin_re;
    assign o_bin_im        = r_bin_im;
    assign o_bin_index     = r_bin_index;
    assign o_last_bin      = r_last_bin;

endmodule

>>> rtl/fft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_ctrl
// configuration registers, frame counters and butterfly sequencer
// ----------------------------------------------------------------------------
module fft_ctrl
    import fft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_op,
    output logic                  o_in_ready,
    output t_dp_cmd               o_cmd,
    input  t_dp_stat              i_stat
);

    t_state            r_state, n_state;
    logic              r_inverse;
    logic [LG_W-1:0]   r_size;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_phase, n_phase;
    logic [LG_W-1:0]   r_stage, n_stage;
    logic [TW_ADDR_W-1:0] r_bf, n_bf;
    logic [LG_W-1:0]   r_lg, n_lg;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic              r_rd_last, n_rd_last;

    logic [LG_W-1:0]      w_lg;
    logic [CNT_W:0]       w_n;
    logic [ADDR_W-1:0]    w_k;
    logic                 w_last;
    logic [ADDR_W-1:0]    w_ld_addr;
    logic [TW_ADDR_W-1:0] w_half_mask, w_j, w_grp, w_bf_end;
    logic [ADDR_W-1:0]    w_addr_a, w_addr_b;
    logic                 w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_size    <= LG_W'(LOG_MAX);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INVERSE: r_inverse <= i_cfg_data[0];
                CFG_SIZE:    r_size    <= i_cfg_data[LG_W-1:0];
                default:     r_inverse <= r_inverse;
            endcase
        end
    end

    // frame position and load address
    always_comb begin
        w_lg      = f_eff_log2(r_size);
        w_n       = (CNT_W+1)'(1) << w_lg;
        w_k       = r_count[ADDR_W-1:0] & ADDR_W'(w_n - (CNT_W+1)'(1));
        w_last    = ((CNT_W+1)'(r_count) + (CNT_W+1)'(1)) >= w_n;
        w_ld_addr = f_bitrev(w_k) >> (LG_W'(LOG_MAX) - w_lg);
    end

    // butterfly addressing: a zero bit inserted at the stage position
    always_comb begin
        w_half_mask = (TW_ADDR_W'(1) << (r_stage - LG_W'(1))) - TW_ADDR_W'(1);
        w_j         = r_bf & w_half_mask;
        w_grp       = r_bf >> (r_stage - LG_W'(1));
        w_addr_a    = (ADDR_W'(w_grp) << r_stage) | ADDR_W'(w_j);
        w_addr_b    = w_addr_a | (ADDR_W'(1) << (r_stage - LG_W'(1)));
        w_bf_end    = (TW_ADDR_W'(1) << (r_lg - LG_W'(1))) - TW_ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_phase   <= 1'b0;
            r_stage   <= LG_W'(1);
            r_bf      <= '0;
            r_lg      <= LG_W'(1);
            r_rd_idx  <= '0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_bf      <= n_bf;
            r_lg      <= n_lg;
            r_rd_idx  <= n_rd_idx;
            r_rd_last <= n_rd_last;
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_bf      = r_bf;
        n_lg      = r_lg;
        n_rd_idx  = r_rd_idx;
        n_rd_last = r_rd_last;
        o_in_ready = 1'b0;

        o_cmd           = '0;
        o_cmd.wr_sel    = WR_LOAD;
        o_cmd.load_conj = r_inverse;
        o_cmd.out_idx   = r_rd_idx;
        o_cmd.out_last  = r_rd_last;
        o_cmd.out_inv   = r_inverse;
        o_cmd.out_lg    = w_lg;
        o_cmd.rd_addr_a = w_addr_a;
        o_cmd.rd_addr_b = w_addr_b;
        o_cmd.tw_addr   = TW_ADDR_W'(w_j << (LG_W'(LOG_MAX) - r_stage));

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept && !i_in_op) begin
                    // a load during readout restarts the frame at count zero
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_phase
                        ? ADDR_W'(0) : w_ld_addr;
                    n_phase = 1'b0;
                    if (!r_phase && w_last) begin
                        n_count = '0;
                        n_stage = LG_W'(1);
                        n_bf    = '0;
                        n_lg    = w_lg;
                        n_state = S_BF_RD;
                    end else if (r_phase) begin
                        n_count = CNT_W'(1);
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (w_accept && r_phase) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_addr_a = w_k;
                    n_rd_idx  = w_k;
                    n_rd_last = w_last;
                    if (w_last) begin
                        n_phase = 1'b0;
                        n_count = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BF_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_BF_ADD;
            end
            S_BF_ADD: begin
                o_cmd.add_en = 1'b1;
                n_state = S_BF_WA;
            end
            S_BF_WA: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_SUM;
                o_cmd.wr_addr = w_addr_a;
                n_state = S_BF_WB;
            end
            S_BF_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_DIF;
                o_cmd.wr_addr = w_addr_b;
                n_state = S_BF_RD;
                if (r_bf == w_bf_end) begin
                    n_bf = '0;
                    if (r_stage == r_lg) begin
                        n_phase = 1'b1;
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_stage = r_stage + LG_W'(1);
                    end
                end else begin
                    n_bf = r_bf + TW_ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/radix2_fft_engine.sv
`timescale 1ns / 1ps
// a load is written to memory on acceptance; a read is registered out of memory,
// then moves to the output register when it is free; the next read waits for that
// the last load starts (N/2)*log2(N) butterflies (24576 at 4096 points):
// each runs read, multiply, add, write sum and write difference on one write port
// reset (synchronous, active low) resets the counters, phase and configuration;
// the frame memory keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
// radix2_fft_engine
// in-place radix-2 decimation-in-time fft with bit-reversed load and ordered readout
// ----------------------------------------------------------------------------
module radix2_fft_engine
    import fft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fft_in_if.sink                i_sample_ch,
    fft_out_if.source             o_bin_ch
);

    // command and status between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller: config, frame counting, butterfly sequencing
    fft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_sample_ch.valid),
        .i_in_op    (i_sample_ch.op),
        .o_in_ready (i_sample_ch.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // datapath: frame memory, twiddle rom, butterfly unit, output register
    fft_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sample_re (i_sample_ch.sample_re),
        .i_sample_im (i_sample_ch.sample_im),
        .i_out_ready (o_bin_ch.ready),
        .o_out_valid (o_bin_ch.valid),
        .o_bin_re    (o_bin_ch.bin_re),
        .o_bin_im    (o_bin_ch.bin_im),
        .o_bin_index (o_bin_ch.bin_index),
        .o_last_bin  (o_bin_ch.last_bin)
    );

endmodule
